FILE: hdl/prac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the point rotation pipeline.
// Depends on nothing; used by prac_cordic_stage and point_rotate_about_center.
package prac_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 32;

    // Datapath widths: offset, CORDIC x/y with 16 guard bits, residual angle
    localparam int DW = 33;
    localparam int XW = 51;
    localparam int ZW = 34;
    localparam int RW = XW - 16;

    // Gain compensation 0.6072529350 in Q2.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // Turn constants in Q16.16 degrees
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd5898240;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd11796480;
    localparam logic signed [ZW-1:0] THREE_QUARTER = 34'sd17694720;
    localparam logic signed [ZW-1:0] FULL_TURN    = 34'sd23592960;

    // Full turn is 45 * 2^19: reduce the top angle bits modulo 45
    localparam logic [13:0] TURN_DIV  = 14'd45;
    localparam logic [13:0] MOD_BIAS  = 14'd4140;
    localparam logic [24:0] DIV_RECIP = 25'd1456;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [29:0] ATAN_Q24 [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29,        30'd14,        30'd7,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
    } t_cordic_word;

endpackage

FILE: hdl/prac_cordic_stage.sv
`timescale 1ns / 1ps
// One registered rotation-mode CORDIC micro-rotation in degrees.
// Depends on prac_pkg for the word type and the arctangent table.
module prac_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  prac_pkg::t_cordic_word i_word,
    output logic                  o_valid,
    output prac_pkg::t_cordic_word o_word
);
    import prac_pkg::*;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step;
    t_cordic_word         n_word;
    t_cordic_word         r_word;
    logic                 r_valid;

    always_comb begin
        xs   = i_word.x >>> SHIFT;
        ys   = i_word.y >>> SHIFT;
        step = $signed({{(ZW-30){1'b0}}, ATAN_Q24[SHIFT]});
        n_word = i_word;
        // rotate toward zero residual angle
        if (!i_word.z[ZW-1]) begin
            n_word.x = i_word.x - ys;
            n_word.y = i_word.y + xs;
            n_word.z = i_word.z - step;
        end else begin
            n_word.x = i_word.x + ys;
            n_word.y = i_word.y - xs;
            n_word.z = i_word.z + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hdl/point_rotate_about_center.sv
`timescale 1ns / 1ps
// Rotates a Q16.16 point about a center by an angle in degrees.
// Depends on prac_pkg and prac_cordic_stage.
//
// Fully pipelined: one point is accepted every clock cycle and o_busy is
// always low. Each result passes through registered stages in this order:
// angle reduction, offset and gain scaling, one CORDIC stage per
// micro-rotation (above 32 counts as 32), then rounding, re-centering and
// saturation. o_valid strobes for exactly one cycle
// per result and the receiver cannot hold it off; results leave in start order.
module point_rotate_about_center #(
    parameter int CORDIC_STAGES = prac_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_angle_deg,
    output logic        o_valid,
    output logic [31:0] o_rotated_x,
    output logic [31:0] o_rotated_y,
    output logic        o_overflow
);
    import prac_pkg::*;

    localparam int NS  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAT = NS + 6;
    localparam logic signed [ZW-1:0] Z_LIMIT = 34'sd1509949440;

    // stage 1: offset, biased angle turns, reciprocal quotient
    logic [13:0]          w_t;
    logic [24:0]          w_qprod;
    logic                 r_s1_valid;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy;
    logic signed [31:0]   r_s1_cx, r_s1_cy;
    logic [13:0]          r_s1_t;
    logic [7:0]           r_s1_q;
    logic [18:0]          r_s1_lo;

    // stage 2: angle modulo a full turn
    logic [13:0]          w_r, w_r2;
    logic                 r_s2_valid;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy;
    logic signed [31:0]   r_s2_cx, r_s2_cy;
    logic [24:0]          r_s2_m;

    // stage 3: fold into [-90, 90]
    logic signed [ZW-1:0] w_m, w_z;
    logic                 w_neg;
    logic                 r_s3_valid;
    logic signed [DW-1:0] r_s3_dx, r_s3_dy;
    logic signed [31:0]   r_s3_cx, r_s3_cy;
    logic signed [ZW-1:0] r_s3_z;

    // stage 4: gain compensation
    logic signed [64:0]   w_px, w_py;
    logic                 r_s4_valid;
    t_cordic_word         r_s4_word;

    // CORDIC chain
    t_cordic_word         w_chain [NS+1];
    logic [NS:0]          w_cv;

    // rounding and output
    logic signed [XW-1:0] w_xr, w_yr;
    logic                 r_r1_valid;
    logic signed [RW-1:0] r_r1_x, r_r1_y;
    logic signed [31:0]   r_r1_cx, r_r1_cy;
    logic signed [RW:0]   w_sx, w_sy;
    logic                 w_ovx, w_ovy;
    logic [31:0]          n_out_x, n_out_y;
    logic                 r_out_valid;
    logic [31:0]          r_out_x, r_out_y;
    logic                 r_out_ovf;

    assign o_busy = 1'b0;

    always_comb begin
        w_t     = {i_angle_deg[31], i_angle_deg[31:19]} + MOD_BIAS;
        w_qprod = {11'b0, w_t} * DIV_RECIP;

        // quotient may run one short: one conditional subtract fixes it
        w_r  = r_s1_t - ({6'b0, r_s1_q} * TURN_DIV);
        w_r2 = (w_r >= TURN_DIV) ? (w_r - TURN_DIV) : w_r;

        w_m   = $signed({{(ZW-25){1'b0}}, r_s2_m});
        w_neg = (w_m > QUARTER_TURN) && (w_m < THREE_QUARTER);
        if (w_neg) begin
            w_z = w_m - HALF_TURN;
        end else if (w_m >= THREE_QUARTER) begin
            w_z = w_m - FULL_TURN;
        end else begin
            w_z = w_m;
        end

        w_px = 65'(r_s3_dx) * 65'(GAIN_Q30) + 65'sd8192;
        w_py = 65'(r_s3_dy) * 65'(GAIN_Q30) + 65'sd8192;

        w_xr = w_chain[NS].x + XW'(32768);
        w_yr = w_chain[NS].y + XW'(32768);

        w_sx  = {r_r1_x[RW-1], r_r1_x} + {{(RW-31){r_r1_cx[31]}}, r_r1_cx};
        w_sy  = {r_r1_y[RW-1], r_r1_y} + {{(RW-31){r_r1_cy[31]}}, r_r1_cy};
        w_ovx = !((&w_sx[RW:31]) || !(|w_sx[RW:31]));
        w_ovy = !((&w_sy[RW:31]) || !(|w_sy[RW:31]));
        if (w_ovx) begin
            n_out_x = w_sx[RW] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            n_out_x = w_sx[31:0];
        end
        if (w_ovy) begin
            n_out_y = w_sy[RW] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            n_out_y = w_sy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_r1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_start && !o_busy;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_r1_valid  <= w_cv[NS];
            r_out_valid <= r_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dx <= $signed({i_point_x[31], i_point_x}) - $signed({i_center_x[31], i_center_x});
        r_s1_dy <= $signed({i_point_y[31], i_point_y}) - $signed({i_center_y[31], i_center_y});
        r_s1_cx <= $signed(i_center_x);
        r_s1_cy <= $signed(i_center_y);
        r_s1_t  <= w_t;
        r_s1_q  <= w_qprod[23:16];
        r_s1_lo <= i_angle_deg[18:0];

        r_s2_dx <= r_s1_dx;
        r_s2_dy <= r_s1_dy;
        r_s2_cx <= r_s1_cx;
        r_s2_cy <= r_s1_cy;
        r_s2_m  <= {w_r2[5:0], r_s1_lo};

        r_s3_dx <= w_neg ? -r_s2_dx : r_s2_dx;
        r_s3_dy <= w_neg ? -r_s2_dy : r_s2_dy;
        r_s3_cx <= r_s2_cx;
        r_s3_cy <= r_s2_cy;
        r_s3_z  <= w_z <<< 8;

        r_s4_word.x  <= w_px[XW+13:14];
        r_s4_word.y  <= w_py[XW+13:14];
        r_s4_word.z  <= r_s3_z;
        r_s4_word.cx <= r_s3_cx;
        r_s4_word.cy <= r_s3_cy;

        r_r1_x  <= w_xr[XW-1:16];
        r_r1_y  <= w_yr[XW-1:16];
        r_r1_cx <= w_chain[NS].cx;
        r_r1_cy <= w_chain[NS].cy;

        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_ovf <= w_ovx || w_ovy;
    end

    assign w_chain[0] = r_s4_word;
    assign w_cv[0]    = r_s4_valid;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        prac_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .i_word  (w_chain[g]),
            .o_valid (w_cv[g+1]),
            .o_word  (w_chain[g+1])
        );
    end

    assign o_valid     = r_out_valid;
    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;
    assign o_overflow  = r_out_ovf;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without a start LAT cycles earlier");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_s3_z <= Z_LIMIT) && (r_s3_z >= -Z_LIMIT))
        else $error("folded angle outside +/-90 degrees");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_rotated_x == 32'h7fff_ffff || o_rotated_x == 32'h8000_0000 ||
             o_rotated_y == 32'h7fff_ffff || o_rotated_y == 32'h8000_0000))
        else $error("overflow flagged without a clamped coordinate");

endmodule

FILE: tb/rotate_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for point_rotate_about_center: a bit-exact predictor of the
// rotation and an in-order check of the results. Depends on nothing.
package rotate_sb_pkg;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] ang;
    } t_point_word;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               ovf;
    } t_rotated_point;

    localparam int     ATAN_LEN      = 32;
    localparam longint FULL_TURN_Q16 = 64'sd23592960;
    localparam longint HALF_TURN_Q16 = 64'sd11796480;
    localparam longint QUART_TURN_Q16 = 64'sd5898240;
    localparam longint GAIN_Q30      = 64'sd652032874;
    localparam int     GAIN_SHIFT    = 14;
    localparam longint GAIN_ROUND    = 64'sd8192;
    localparam int     GUARD_BITS    = 16;
    localparam longint GUARD_ROUND   = 64'sd32768;
    localparam longint Q16_TO_Q24    = 64'sd256;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;

    class rotate_scoreboard;
        int             stages;
        int             errors;
        t_rotated_point expected_q[$];
        longint         atan_q24[ATAN_LEN];

        function new(int stage_count);
            stages = (stage_count > ATAN_LEN) ? ATAN_LEN : stage_count;
            errors = 0;
            atan_q24 = '{
                754974720, 445687602, 235489088, 119537938,
                60000934,  30029717,  15018523,  7509720,
                3754917,   1877466,   938734,    469367,
                234684,    117342,    58671,     29335,
                14668,     7334,      3667,      1833,
                917,       458,       229,       115,
                57,        29,        14,        7,
                4,         2,         1,         0
            };
        endfunction

        function automatic longint clamp32(longint v, ref logic ovf);
            if (v > SAT_HI) begin
                ovf = 1'b1;
                return SAT_HI;
            end
            if (v < SAT_LO) begin
                ovf = 1'b1;
                return SAT_LO;
            end
            return v;
        endfunction

        function automatic t_rotated_point rotate_point(t_point_word w);
            longint         dx, dy, m, x, y, z, xs, ys, rx, ry;
            logic           ovf;
            t_rotated_point r;
            dx = longint'(w.px) - longint'(w.cx);
            dy = longint'(w.py) - longint'(w.cy);
            m = longint'(w.ang) % FULL_TURN_Q16;
            if (m < 0) m += FULL_TURN_Q16;
            if (m > HALF_TURN_Q16) m -= FULL_TURN_Q16;
            // fold into [-90,90]: a half turn is a negated offset
            if (m > QUART_TURN_Q16) begin
                dx = -dx;
                dy = -dy;
                m -= HALF_TURN_Q16;
            end else if (m < -QUART_TURN_Q16) begin
                dx = -dx;
                dy = -dy;
                m += HALF_TURN_Q16;
            end
            x = (dx * GAIN_Q30 + GAIN_ROUND) >>> GAIN_SHIFT;
            y = (dy * GAIN_Q30 + GAIN_ROUND) >>> GAIN_SHIFT;
            z = m * Q16_TO_Q24;
            for (int i = 0; i < stages; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_q24[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_q24[i];
                end
            end
            rx = ((x + GUARD_ROUND) >>> GUARD_BITS) + longint'(w.cx);
            ry = ((y + GUARD_ROUND) >>> GUARD_BITS) + longint'(w.cy);
            ovf = 1'b0;
            rx = clamp32(rx, ovf);
            ry = clamp32(ry, ovf);
            r.rx = 32'(rx);
            r.ry = 32'(ry);
            r.ovf = ovf;
            return r;
        endfunction

        function void note_word(t_point_word w);
            expected_q.push_back(rotate_point(w));
        endfunction

        function void report(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [31:0] rx, logic [31:0] ry, logic ovf);
            t_rotated_point e;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none pending: x %h y %h ovf %b",
                                 rx, ry, ovf));
                return;
            end
            e = expected_q.pop_front();
            if (rx !== e.rx)
                report($sformatf("rotated_x expected %h got %h", e.rx, rx));
            if (ry !== e.ry)
                report($sformatf("rotated_y expected %h got %h", e.ry, ry));
            if (ovf !== e.ovf)
                report($sformatf("overflow expected %b got %b", e.ovf, ovf));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top of the point_rotate_about_center testbench: clock, reset, stimulus and
// result monitor. Depends on prac_pkg, rotate_sb_pkg and the block itself.
module tb;
    import rotate_sb_pkg::*;

    localparam int STAGES          = prac_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY         = STAGES + 6;
    localparam int ONE_DEG         = 65536;
    localparam int ONE_Q16         = 65536;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int NUM_PHASES      = 4;
    localparam logic [31:0] MAXV   = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV   = 32'h8000_0000;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_start     = 1'b0;
    logic [31:0] i_point_x   = '0;
    logic [31:0] i_point_y   = '0;
    logic [31:0] i_center_x  = '0;
    logic [31:0] i_center_y  = '0;
    logic [31:0] i_angle_deg = '0;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_rotated_x;
    logic [31:0] o_rotated_y;
    logic        o_overflow;

    rotate_scoreboard rot_sb = new(STAGES);

    point_rotate_about_center #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_angle_deg (i_angle_deg),
        .o_valid     (o_valid),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0)
            rot_sb.check_result(o_rotated_x, o_rotated_y, o_overflow);
    end

    // hold start high until the word is taken
    task automatic drive_word(input logic [31:0] px, py, cx, cy, ang);
        t_point_word w;
        w.px = px;
        w.py = py;
        w.cx = cx;
        w.cy = cy;
        w.ang = ang;
        i_start     <= 1'b1;
        i_point_x   <= px;
        i_point_y   <= py;
        i_center_x  <= cx;
        i_center_y  <= cy;
        i_angle_deg <= ang;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        rot_sb.note_word(w);
    endtask

    task automatic hold_idle(input int pct);
        while ($urandom_range(99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (rot_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(input int base, input int span);
        return base + int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic [31:0] extreme_word();
        return ($urandom_range(1) ? 32'h7F00_0000 : 32'h8000_0000)
               | ($urandom & 32'h00FF_FFFF);
    endfunction

    task automatic send_random_word();
        logic [31:0] px, py, cx, cy, ang;
        int          kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                px = $urandom;
                py = $urandom;
                cx = $urandom;
                cy = $urandom;
                ang = $urandom;
            end
            3, 4, 5: begin
                cx = near(0, 1 << 24);
                cy = near(0, 1 << 24);
                px = cx + near(0, 1 << 20);
                py = cy + near(0, 1 << 20);
                ang = near(0, 720 * ONE_DEG);
            end
            6: begin
                // land on or next to a multiple of a quarter turn
                cx = near(0, 1 << 24);
                cy = near(0, 1 << 24);
                px = cx + near(0, 1 << 22);
                py = cy + near(0, 1 << 22);
                ang = (int'($urandom_range(16)) - 8) * 90 * ONE_DEG + near(0, 4);
            end
            7: begin
                px = extreme_word();
                py = extreme_word();
                cx = extreme_word();
                cy = extreme_word();
                ang = $urandom;
            end
            8: begin
                px = $urandom;
                py = $urandom;
                cx = px;
                cy = py;
                ang = $urandom;
            end
            default: begin
                px = $urandom;
                py = $urandom;
                cx = $urandom;
                cy = $urandom;
                ang = near(0, 360 * ONE_DEG);
            end
        endcase
        drive_word(px, py, cx, cy, ang);
    endtask

    initial begin
        int idle_pct[NUM_PHASES];
        idle_pct = '{0, 88, 16, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drive_word(0, 0, 0, 0, 0);
        drive_word(ONE_Q16, 0, 0, 0, 90 * ONE_DEG);
        drive_word(ONE_Q16, 0, 0, 0, -90 * ONE_DEG);
        drive_word(ONE_Q16, 2 * ONE_Q16, 0, 0, 180 * ONE_DEG);
        drive_word(ONE_Q16, 2 * ONE_Q16, 0, 0, -180 * ONE_DEG);
        // just past the fold points
        drive_word(3 * ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, 90 * ONE_DEG + 1);
        drive_word(3 * ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, -90 * ONE_DEG - 1);
        drive_word(-5 * ONE_Q16, 7 * ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16,
                   180 * ONE_DEG + 1);
        drive_word(4 * ONE_Q16, ONE_Q16, 0, ONE_Q16, 270 * ONE_DEG);
        drive_word(4 * ONE_Q16, ONE_Q16, 0, ONE_Q16, 360 * ONE_DEG);
        drive_word(10 * ONE_Q16, 0, 0, 0, 45 * ONE_DEG);
        drive_word(10 * ONE_Q16, 3 * ONE_Q16, 0, 0, 1);
        drive_word(10 * ONE_Q16, 3 * ONE_Q16, 0, 0, -1);
        drive_word(12345678, -7654321, 1000, -2000, MAXV);
        drive_word(12345678, -7654321, 1000, -2000, MINV);
        // saturation of both coordinates, high and low
        drive_word(MAXV, MAXV, MINV, MINV, 0);
        drive_word(MAXV, MAXV, MINV, MINV, 180 * ONE_DEG);
        drive_word(MINV, MINV, MAXV, MAXV, 180 * ONE_DEG);
        // saturation of one coordinate only, then points that sit on their center
        drive_word(MAXV, MINV, 0, 0, 45 * ONE_DEG);
        drive_word(MAXV, MINV, 0, 0, -45 * ONE_DEG);
        drive_word(MAXV, 0, 0, 0, 90 * ONE_DEG);
        drive_word(MAXV, MAXV, MAXV, MAXV, 123 * ONE_DEG);
        drive_word(MINV, MINV, MINV, MINV, -77 * ONE_DEG);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            repeat (ITEMS_PER_PHASE) begin
                hold_idle(idle_pct[p]);
                send_random_word();
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (rot_sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/prac_pkg.sv
hdl/prac_cordic_stage.sv
hdl/point_rotate_about_center.sv
tb/rotate_scoreboard.sv
tb/tb.sv
